// ===== hw/rtl/lpc_pkg.sv =====
package lpc_pkg;

   localparam int COORD_W  = 32;
   localparam int ENTRY_W  = 16;
   localparam int ROW_W    = 64;
   localparam int SIZE_W   = 14;
   localparam int COLOR_W  = 32;
   localparam int CSR_AW   = 6;

   // divider geometry
   localparam int DIV_NW        = 33;
   localparam int CLIP_QB       = 30;
   localparam int VIEW_QB       = 31;
   localparam int DIV_STEP_BITS = 2;

   // register indexes (paddr / 8)
   localparam logic [2:0] REG_ROW0   = 3'd0;
   localparam logic [2:0] REG_ROW1   = 3'd1;
   localparam logic [2:0] REG_ROW2   = 3'd2;
   localparam logic [2:0] REG_ROW3   = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type vec4_type [4];
   typedef coord_type vec3_type [3];

   function automatic coord_type sat_coord(input logic signed [63:0] v);
      coord_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/lpc_div.sv =====
module lpc_div #(
   parameter int LANES = 1,
   parameter int NW    = 33,
   parameter int QB    = 30,
   parameter int STEP  = 2,
   parameter int PW    = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_vld,
   input  logic [NW-1:0] in_rem [LANES],
   input  logic [QB-1:0] in_low [LANES],
   input  logic [NW-1:0] in_den [LANES],
   input  logic [PW-1:0] in_pay,
   output logic          out_vld,
   output logic [QB-1:0] out_quo [LANES],
   output logic [PW-1:0] out_pay
);
   localparam int STAGES = (QB + STEP - 1) / STEP;

   logic          vld_ff [STAGES];
   logic [PW-1:0] pay_ff [STAGES];
   logic [NW-1:0] rem_ff [STAGES][LANES];
   logic [NW-1:0] den_ff [STAGES][LANES];
   logic [QB-1:0] low_ff [STAGES][LANES];
   logic [QB-1:0] quo_ff [STAGES][LANES];

   logic [NW-1:0] rem_in [STAGES][LANES];
   logic [NW-1:0] den_in [STAGES][LANES];
   logic [QB-1:0] low_in [STAGES][LANES];
   logic [QB-1:0] quo_in [STAGES][LANES];

   // restoring division, up to STEP quotient bits per stage, MSB first
   always_comb begin
      logic [NW-1:0] r;
      logic [NW-1:0] dv;
      logic [QB-1:0] l;
      logic [QB-1:0] q;
      logic [NW:0]   t;
      logic [NW+1:0] d;
      for (int s = 0; s < STAGES; s++) begin
         for (int ln = 0; ln < LANES; ln++) begin
            if (s == 0) begin
               r  = in_rem[ln];
               dv = in_den[ln];
               l  = in_low[ln];
               q  = '0;
            end else begin
               r  = rem_ff[s-1][ln];
               dv = den_ff[s-1][ln];
               l  = low_ff[s-1][ln];
               q  = quo_ff[s-1][ln];
            end
            for (int b = 0; b < STEP; b++) begin
               if (s * STEP + b < QB) begin
                  t = {r, l[QB-1]};
                  d = {1'b0, t} - {2'b00, dv};
                  l = {l[QB-2:0], 1'b0};
                  if (!d[NW+1]) begin
                     r = d[NW-1:0];
                     q = {q[QB-2:0], 1'b1};
                  end else begin
                     r = t[NW-1:0];
                     q = {q[QB-2:0], 1'b0};
                  end
               end
            end
            rem_in[s][ln] = r;
            den_in[s][ln] = dv;
            low_in[s][ln] = l;
            quo_in[s][ln] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < STAGES; s++) begin
            if (s == 0) vld_ff[s] <= in_vld;
            else        vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < STAGES; s++) begin
            if (s == 0) pay_ff[s] <= in_pay;
            else        pay_ff[s] <= pay_ff[s-1];
            for (int ln = 0; ln < LANES; ln++) begin
               rem_ff[s][ln] <= rem_in[s][ln];
               den_ff[s][ln] <= den_in[s][ln];
               low_ff[s][ln] <= low_in[s][ln];
               quo_ff[s][ln] <= quo_in[s][ln];
            end
         end
      end
   end

   assign out_vld = vld_ff[STAGES-1];
   assign out_pay = pay_ff[STAGES-1];
   always_comb begin
      for (int ln = 0; ln < LANES; ln++) out_quo[ln] = quo_ff[STAGES-1][ln];
   end

endmodule

// ===== hw/rtl/lpc_xform.sv =====
module lpc_xform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_vld,
   input  lpc_pkg::vec4_type                 in_vec [2],
   input  logic [lpc_pkg::COLOR_W-1:0]       in_color,
   input  logic [lpc_pkg::ROW_W-1:0]         matrix [4],
   output logic                              out_vld,
   output lpc_pkg::vec4_type                 out_t [2],
   output logic [lpc_pkg::COLOR_W-1:0]       out_color
);
   import lpc_pkg::*;

   logic                     p_vld_ff;
   logic signed [47:0]       prod_ff [2][4][4];
   logic [COLOR_W-1:0]       p_color_ff;
   logic                     t_vld_ff;
   vec4_type                 t_ff [2];
   vec4_type                 t_in [2];
   logic [COLOR_W-1:0]       t_color_ff;

   // row vector times matrix: product [e][i][j] = v[i] * M[i][j]
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++)
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 4; j++)
                  prod_ff[e][i][j] <= in_vec[e][i] * $signed(matrix[i][ENTRY_W*j +: ENTRY_W]);
         p_color_ff <= in_color;
         t_ff       <= t_in;
         t_color_ff <= p_color_ff;
      end
   end

   // column sums, round to Q16.16, saturate
   always_comb begin
      logic signed [49:0] acc;
      logic signed [49:0] sh;
      for (int e = 0; e < 2; e++) begin
         for (int j = 0; j < 4; j++) begin
            acc = 50'sd512;
            for (int i = 0; i < 4; i++) acc = acc + 50'(prod_ff[e][i][j]);
            sh = acc >>> 10;
            t_in[e][j] = sat_coord(64'(sh));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         t_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= in_vld;
         t_vld_ff <= p_vld_ff;
      end
   end

   assign out_vld   = t_vld_ff;
   assign out_t     = t_ff;
   assign out_color = t_color_ff;

endmodule

// ===== hw/rtl/lpc_clip.sv =====
module lpc_clip #(
   parameter int STEP = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_vld,
   input  lpc_pkg::vec4_type                 in_t [2],
   input  logic [lpc_pkg::COLOR_W-1:0]       in_color,
   output logic                              out_vld,
   output lpc_pkg::vec3_type                 out_pt [2],
   output logic [lpc_pkg::COLOR_W-1:0]       out_color
);
   import lpc_pkg::*;

   typedef struct packed {
      logic [COLOR_W-1:0]             color;
      logic                           pull_a;
      logic                           pull_b;
      logic [5:0][COORD_W-1:0]        pts;   // a.x a.y a.w b.x b.y b.w
   } pay_type;

   localparam int PW = $bits(pay_type);

   logic          a_neg, b_neg, keep;
   coord_type     fz, pz;
   logic [DIV_NW-1:0] d_rem [1];
   logic [DIV_NW-1:0] d_den [1];
   logic [CLIP_QB-1:0] d_low [1];
   logic [CLIP_QB-1:0] d_quo [1];
   pay_type       d_pay_in, d_pay_out;
   logic [PW-1:0] d_pay_raw;
   logic          d_vld;

   always_comb begin
      a_neg = in_t[0][2][COORD_W-1];
      b_neg = in_t[1][2][COORD_W-1];
      keep  = in_vld && !(a_neg && b_neg);
      d_pay_in.color  = in_color;
      d_pay_in.pull_a = a_neg && !b_neg;
      d_pay_in.pull_b = b_neg && !a_neg;
      d_pay_in.pts[0] = in_t[0][0];
      d_pay_in.pts[1] = in_t[0][1];
      d_pay_in.pts[2] = in_t[0][3];
      d_pay_in.pts[3] = in_t[1][0];
      d_pay_in.pts[4] = in_t[1][1];
      d_pay_in.pts[5] = in_t[1][3];
      fz = a_neg ? in_t[1][2] : in_t[0][2];
      pz = a_neg ? in_t[0][2] : in_t[1][2];
      // fraction fz / (fz - pz), front z over front minus behind; only meaningful with exactly one behind
      if (d_pay_in.pull_a || d_pay_in.pull_b) begin
         d_rem[0] = {2'b00, fz[COORD_W-2:0]};
         d_den[0] = 33'(fz) - 33'(pz);
      end else begin
         d_rem[0] = '0;
         d_den[0] = 33'd1;
      end
      d_low[0] = '0;
   end

   lpc_div #(
      .LANES(1), .NW(DIV_NW), .QB(CLIP_QB), .STEP(STEP), .PW(PW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (keep),
      .in_rem  (d_rem),
      .in_low  (d_low),
      .in_den  (d_den),
      .in_pay  (d_pay_in),
      .out_vld (d_vld),
      .out_quo (d_quo),
      .out_pay (d_pay_raw)
   );

   assign d_pay_out = pay_type'(d_pay_raw);

   // C1: q / 1000 estimate by reciprocal (floor or one above)
   logic                c1_vld_ff;
   logic [CLIP_QB-1:0]  c1_q_ff;
   logic [20:0]         c1_t_ff;
   pay_type             c1_pay_ff;
   logic [50:0]         c1_prod;

   assign c1_prod = {21'b0, d_quo[0]} * 51'd1073742;

   // C2: exact ceil(q/1000), s = q - ceil = floor(q*999/1000)
   logic                c2_vld_ff;
   logic [CLIP_QB-1:0]  c2_s_ff;
   pay_type             c2_pay_ff;
   logic signed [31:0]  c2_rem, c2_remc;
   logic [31:0]         c2_tk;
   logic [20:0]         c2_fl;
   logic [CLIP_QB-1:0]  c2_s;

   always_comb begin
      c2_tk  = {11'b0, c1_t_ff} * 32'd1000;
      c2_rem = $signed({2'b00, c1_q_ff}) - $signed(c2_tk);
      if (c2_rem < 0) begin
         c2_fl   = c1_t_ff - 21'd1;
         c2_remc = c2_rem + 32'sd1000;
      end else begin
         c2_fl   = c1_t_ff;
         c2_remc = c2_rem;
      end
      c2_s = c1_q_ff - 30'(c2_fl) - 30'(c2_remc != 0);
   end

   // C3: (behind - front) * s
   logic                c3_vld_ff;
   logic signed [63:0]  c3_prod_ff [3];
   pay_type             c3_pay_ff;

   // C4: front + rounded step, saturate, put back in place
   logic                c4_vld_ff;
   vec3_type            c4_pt_ff [2];
   logic [COLOR_W-1:0]  c4_color_ff;
   vec3_type            c4_pt_in [2];

   always_comb begin
      logic signed [63:0] rnd;
      coord_type          fr;
      coord_type          res;
      for (int k = 0; k < 3; k++) begin
         fr  = c3_pay_ff.pull_a ? c3_pay_ff.pts[3+k] : c3_pay_ff.pts[k];
         rnd = (c3_prod_ff[k] + 64'sd536870912) >>> 30;
         res = sat_coord(64'(fr) + rnd);
         c4_pt_in[0][k] = c3_pay_ff.pull_a ? res : coord_type'(c3_pay_ff.pts[k]);
         c4_pt_in[1][k] = c3_pay_ff.pull_b ? res : coord_type'(c3_pay_ff.pts[3+k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_q_ff   <= d_quo[0];
         c1_t_ff   <= c1_prod[50:30];
         c1_pay_ff <= d_pay_out;
         c2_s_ff   <= c2_s;
         c2_pay_ff <= c1_pay_ff;
         for (int k = 0; k < 3; k++) begin
            c3_prod_ff[k] <= (c2_pay_ff.pull_a
               ? (33'($signed(c2_pay_ff.pts[k])) - 33'($signed(c2_pay_ff.pts[3+k])))
               : (33'($signed(c2_pay_ff.pts[3+k])) - 33'($signed(c2_pay_ff.pts[k]))))
               * $signed({1'b0, c2_s_ff});
         end
         c3_pay_ff   <= c2_pay_ff;
         c4_pt_ff    <= c4_pt_in;
         c4_color_ff <= c3_pay_ff.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
         c3_vld_ff <= 1'b0;
         c4_vld_ff <= 1'b0;
      end else if (adv) begin
         c1_vld_ff <= d_vld;
         c2_vld_ff <= c1_vld_ff;
         c3_vld_ff <= c2_vld_ff;
         c4_vld_ff <= c3_vld_ff;
      end
   end

   assign out_vld   = c4_vld_ff;
   assign out_pt    = c4_pt_ff;
   assign out_color = c4_color_ff;

endmodule

// ===== hw/rtl/lpc_view.sv =====
module lpc_view #(
   parameter int STEP = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_vld,
   input  lpc_pkg::vec3_type                 in_pt [2],
   input  logic [lpc_pkg::COLOR_W-1:0]       in_color,
   input  logic [lpc_pkg::SIZE_W-1:0]        width,
   input  logic [lpc_pkg::SIZE_W-1:0]        height,
   output logic                              out_vld,
   output lpc_pkg::coord_type                out_s [4],
   output logic [lpc_pkg::COLOR_W-1:0]       out_color
);
   import lpc_pkg::*;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [3:0]         dz;
      logic [3:0]         pos;
      logic [3:0]         negn;
      logic [3:0]         ovf;
      logic [3:0]         neg;
   } pay_type;

   localparam int PW = $bits(pay_type);

   // V1: numerators times size, denominators 2w; lanes x0 y0 x1 y1
   logic                v1_vld_ff;
   logic signed [47:0]  v1_n_ff [4];
   logic signed [32:0]  v1_d_ff [4];
   logic [COLOR_W-1:0]  v1_color_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 2; e++) begin
            v1_n_ff[2*e]   <= (33'(in_pt[e][0]) + 33'(in_pt[e][2])) * $signed({1'b0, width});
            v1_n_ff[2*e+1] <= (33'(in_pt[e][2]) - 33'(in_pt[e][1])) * $signed({1'b0, height});
            v1_d_ff[2*e]   <= {in_pt[e][2], 1'b0};
            v1_d_ff[2*e+1] <= {in_pt[e][2], 1'b0};
         end
         v1_color_ff <= in_color;
      end
   end

   // V2: magnitudes, half-divisor bias, overflow test, into the divider
   logic [DIV_NW-1:0]  d_rem [4];
   logic [DIV_NW-1:0]  d_den [4];
   logic [VIEW_QB-1:0] d_low [4];
   logic [VIEW_QB-1:0] d_quo [4];
   pay_type            d_pay_in, d_pay_out;
   logic [PW-1:0]      d_pay_raw;
   logic               d_vld;

   always_comb begin
      logic signed [63:0] num;
      logic [63:0]        un;
      logic [DIV_NW-1:0]  ud;
      logic [63:0]        npr;
      logic [DIV_NW-1:0]  hi;
      logic               dz;
      logic               ov;
      d_pay_in.color = v1_color_ff;
      for (int ln = 0; ln < 4; ln++) begin
         num = {v1_n_ff[ln], 16'b0};
         un  = num[63] ? (64'd0 - num) : num;
         ud  = v1_d_ff[ln][32] ? (33'd0 - v1_d_ff[ln]) : v1_d_ff[ln];
         npr = un + {32'b0, ud[DIV_NW-1:1]};
         hi  = npr[63:VIEW_QB];
         dz  = (ud == '0);
         ov  = !dz && (hi >= ud);
         d_pay_in.dz[ln]   = dz;
         d_pay_in.pos[ln]  = !num[63] && (num != 0);
         d_pay_in.negn[ln] = num[63];
         d_pay_in.ovf[ln]  = ov;
         d_pay_in.neg[ln]  = num[63] ^ v1_d_ff[ln][32];
         d_rem[ln] = (dz || ov) ? '0 : hi;
         d_den[ln] = dz ? 33'd1 : ud;
         d_low[ln] = npr[VIEW_QB-1:0];
      end
   end

   lpc_div #(
      .LANES(4), .NW(DIV_NW), .QB(VIEW_QB), .STEP(STEP), .PW(PW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (v1_vld_ff),
      .in_rem  (d_rem),
      .in_low  (d_low),
      .in_den  (d_den),
      .in_pay  (d_pay_in),
      .out_vld (d_vld),
      .out_quo (d_quo),
      .out_pay (d_pay_raw)
   );

   assign d_pay_out = pay_type'(d_pay_raw);

   // V3: sign and saturation into the output register
   logic                o_vld_ff;
   coord_type           o_s_ff [4];
   coord_type           o_s_in [4];
   logic [COLOR_W-1:0]  o_color_ff;

   always_comb begin
      for (int ln = 0; ln < 4; ln++) begin
         priority if (d_pay_out.dz[ln]) begin
            o_s_in[ln] = d_pay_out.pos[ln] ? 32'sh7FFFFFFF :
                         d_pay_out.negn[ln] ? 32'sh80000000 : 32'sh0;
         end else if (d_pay_out.ovf[ln]) begin
            o_s_in[ln] = d_pay_out.neg[ln] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            o_s_in[ln] = d_pay_out.neg[ln] ? (32'd0 - {1'b0, d_quo[ln]})
                                           : {1'b0, d_quo[ln]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_s_ff     <= o_s_in;
         o_color_ff <= d_pay_out.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else if (adv) begin
         v1_vld_ff <= in_vld;
         o_vld_ff  <= d_vld;
      end
   end

   assign out_vld   = o_vld_ff;
   assign out_s     = o_s_ff;
   assign out_color = o_color_ff;

endmodule

// ===== hw/rtl/line_project_clip_to_screen_core.sv =====
// Throughput: one segment per cycle while the output is not stalled; the two pipelined
// restoring dividers set the depth.
// A stalled output freezes the whole pipe; it moves again as soon as the result is taken.
// Segments with both endpoints behind the camera are dropped in flight (no result).
// Reset (synchronous) clears all valid bits and loads the identity matrix and a 1920x1080 view.
module line_project_clip_to_screen_core #(
   parameter int DIV_STEP_BITS = lpc_pkg::DIV_STEP_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // segment input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_start_x,
   input  logic signed [31:0]                req_start_y,
   input  logic signed [31:0]                req_start_z,
   input  logic signed [31:0]                req_start_w,
   input  logic signed [31:0]                req_end_x,
   input  logic signed [31:0]                req_end_y,
   input  logic signed [31:0]                req_end_z,
   input  logic signed [31:0]                req_end_w,
   input  logic [31:0]                       req_line_color,
   // screen result
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_screen_x0,
   output logic signed [31:0]                rsp_screen_y0,
   output logic signed [31:0]                rsp_screen_x1,
   output logic signed [31:0]                rsp_screen_y1,
   output logic [31:0]                       rsp_out_color,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lpc_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [lpc_pkg::ROW_W-1:0]         csr_pwdata,
   output logic [lpc_pkg::ROW_W-1:0]         csr_prdata,
   output logic                              csr_pready
);
   import lpc_pkg::*;

   // ---------------------------------------------------------------
   // Registers: four 64-bit matrix rows, then width and height.
   // Each register sits at 8 * index; the index is paddr[5:3].
   // ---------------------------------------------------------------
   logic [ROW_W-1:0]  row_ff [4];
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [2:0]        csr_idx;
   logic              csr_wr;

   assign csr_idx    = csr_paddr[CSR_AW-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= 64'd1024;
         row_ff[1] <= 64'd1024 << 16;
         row_ff[2] <= 64'd1024 << 32;
         row_ff[3] <= 64'd1024 << 48;
         width_ff  <= 14'd1920;
         height_ff <= 14'd1080;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ROW0:   row_ff[0] <= csr_pwdata;
            REG_ROW1:   row_ff[1] <= csr_pwdata;
            REG_ROW2:   row_ff[2] <= csr_pwdata;
            REG_ROW3:   row_ff[3] <= csr_pwdata;
            REG_WIDTH:  width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[SIZE_W-1:0];
            default: ;  // unmapped: ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ROW0:   csr_prdata = row_ff[0];
         REG_ROW1:   csr_prdata = row_ff[1];
         REG_ROW2:   csr_prdata = row_ff[2];
         REG_ROW3:   csr_prdata = row_ff[3];
         REG_WIDTH:  csr_prdata = {{(ROW_W-SIZE_W){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(ROW_W-SIZE_W){1'b0}}, height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Flow control: every stage moves together. The pipe advances
   // unless the output register holds a result the sink is stalling;
   // empty slots (dropped segments, idle cycles) simply travel along.
   // ---------------------------------------------------------------
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------
   // Transform: 32 products, then column sums with Q16.16 rounding.
   // ---------------------------------------------------------------
   vec4_type           in_vec [2];
   vec4_type           xf_t [2];
   logic               xf_vld;
   logic [COLOR_W-1:0] xf_color;

   assign in_vec[0][0] = req_start_x;
   assign in_vec[0][1] = req_start_y;
   assign in_vec[0][2] = req_start_z;
   assign in_vec[0][3] = req_start_w;
   assign in_vec[1][0] = req_end_x;
   assign in_vec[1][1] = req_end_y;
   assign in_vec[1][2] = req_end_z;
   assign in_vec[1][3] = req_end_w;

   lpc_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (req_valid && !req_stall),
      .in_vec    (in_vec),
      .in_color  (req_line_color),
      .matrix    (row_ff),
      .out_vld   (xf_vld),
      .out_t     (xf_t),
      .out_color (xf_color)
   );

   // ---------------------------------------------------------------
   // Near clip: drop both-behind; with exactly one behind, pull that endpoint
   // to 0.999 of the z = 0 crossing (fraction from a pipelined divider).
   // ---------------------------------------------------------------
   vec3_type           cl_pt [2];
   logic               cl_vld;
   logic [COLOR_W-1:0] cl_color;

   lpc_clip #(.STEP(DIV_STEP_BITS)) u_clip (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (xf_vld),
      .in_t      (xf_t),
      .in_color  (xf_color),
      .out_vld   (cl_vld),
      .out_pt    (cl_pt),
      .out_color (cl_color)
   );

   // ---------------------------------------------------------------
   // Viewport: four rounded, saturated quotients in parallel lanes;
   // its last register is the output register.
   // ---------------------------------------------------------------
   coord_type vw_s [4];

   lpc_view #(.STEP(DIV_STEP_BITS)) u_view (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (cl_vld),
      .in_pt     (cl_pt),
      .in_color  (cl_color),
      .width     (width_ff),
      .height    (height_ff),
      .out_vld   (rsp_valid),
      .out_s     (vw_s),
      .out_color (rsp_out_color)
   );

   assign rsp_screen_x0 = vw_s[0];
   assign rsp_screen_y0 = vw_s[1];
   assign rsp_screen_x1 = vw_s[2];
   assign rsp_screen_y1 = vw_s[3];

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output register free");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_width_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_WIDTH) |=> (width_ff == $past(csr_pwdata[SIZE_W-1:0])))
      else $error("width register write lost");

endmodule
